// ===== src/rkml_pkg.sv =====
// ----------------------------------------------------------------------------
// rkml_pkg
// shared types and constants for the retired key match list
// ----------------------------------------------------------------------------
`default_nettype none

package rkml_pkg;

    localparam int unsigned LIST_DEPTH_DEF = 16;
    localparam int unsigned GEN_W          = 64;
    localparam int unsigned PRINT_W        = 64;
    localparam int unsigned OCC_W          = 5;

    // opcode carried in the slave-side tuser
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_RETIRE = 1'b1;

    // one stored or queried (generation, fingerprint) pair
    typedef struct packed {
        logic [GEN_W-1:0]   gen;
        logic [PRINT_W-1:0] print;
    } t_pair;

endpackage

`default_nettype wire

// ===== src/rkml_cell.sv =====
// ----------------------------------------------------------------------------
// rkml_cell
// one list entry: holds a pair, shifts it on to the next cell, compares a query
// ----------------------------------------------------------------------------
`default_nettype none

module rkml_cell (
    input  wire              i_clk,
    input  wire              i_shift,     // load i_prev into this cell
    input  rkml_pkg::t_pair  i_prev,      // pair from the newer neighbor
    input  rkml_pkg::t_pair  i_query,     // broadcast lookup pair
    input  wire              i_occupied,  // this position is below the count
    output rkml_pkg::t_pair  o_entry,     // stored pair, to the older neighbor
    output logic             o_match
);

    rkml_pkg::t_pair r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_prev;
        end
    end

    assign o_entry = r_entry;
    assign o_match = i_occupied &&
                     ((r_entry.gen == i_query.gen) || (r_entry.print == i_query.print));

endmodule

`default_nettype wire

// ===== src/retired_key_match_list_unit.sv =====
// ----------------------------------------------------------------------------
// retired_key_match_list_unit
// bounded list of retired (generation, fingerprint) pairs with associative match
// ----------------------------------------------------------------------------
// Each transaction on the slave side is a lookup (tuser = 0) or a retire
// (tuser = 1) of one (generation, fingerprint) pair and produces exactly one
// result transaction on the master side. The list is a row of LIST_DEPTH cells;
// a retire pushes the new pair into cell 0 and every cell hands its pair to the
// next, so the oldest entry sits at position count-1 and falls off the end when
// the list is full (the result then flags the eviction). A lookup compares the
// query against all occupied cells in parallel and reports a hit when any
// generation or fingerprint matches. Each result is registered in the cycle after
// its item is accepted; a new item is accepted every cycle as long as the result
// register is empty or being drained, so the rate is one item per cycle, set by
// the parallel compare across the cell row. Occupancy is reported as the low
// five bits of the entry count.
// ----------------------------------------------------------------------------
`default_nettype none

module retired_key_match_list_unit #(
    parameter int unsigned LIST_DEPTH = rkml_pkg::LIST_DEPTH_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    // slave side
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire [127:0]  i_s_axis_tdata,   // [63:0] generation, [127:64] key_print
    input  wire          i_s_axis_tuser,   // [0] opcode
    // master side
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    output logic [7:0]   o_m_axis_tdata    // [0] hit, [1] evicted, [6:2] occupancy, [7] zero
);

    localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    // input transaction
    rkml_pkg::t_pair query;
    logic            s_accept;
    logic            is_retire;

    assign query.gen   = i_s_axis_tdata[63:0];
    assign query.print = i_s_axis_tdata[127:64];
    assign is_retire   = (i_s_axis_tuser == rkml_pkg::OP_RETIRE);

    // output register: accept while empty or while the result is taken
    logic r_m_tvalid;
    logic r_hit;
    logic r_evicted;
    logic [rkml_pkg::OCC_W-1:0] r_occ;

    assign o_s_axis_tready = !r_m_tvalid || i_m_axis_tready;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // entry count
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             full;

    assign full = (r_count == DEPTH_C);

    always_comb begin
        n_count = r_count;
        if (s_accept && is_retire && !full) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // cell row, cell 0 holds the newest pair
    rkml_pkg::t_pair             entries [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]       match_vec;
    logic                        shift_en;

    assign shift_en = s_accept && is_retire;

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
            rkml_pkg::t_pair prev;
            if (g == 0) begin : g_head
                assign prev = query;
            end else begin : g_body
                assign prev = entries[g-1];
            end

            rkml_cell u_cell (
                .i_clk      (i_clk),
                .i_shift    (shift_en),
                .i_prev     (prev),
                .i_query    (query),
                .i_occupied (CNT_W'(g) < r_count),
                .o_entry    (entries[g]),
                .o_match    (match_vec[g])
            );
        end
    endgenerate

    // state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (s_accept) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_hit     <= !is_retire && (|match_vec);
            r_evicted <= is_retire && full;
            r_occ     <= rkml_pkg::OCC_W'(n_count);
        end
    end

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = {1'b0, r_occ, r_evicted, r_hit};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count beyond list depth");

    a_evict_on_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && is_retire && full) |=> (r_m_tvalid && r_evicted && (r_count == DEPTH_C)))
        else $error("retire into a full list did not evict");

    a_lookup_keeps_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !is_retire) |=> $stable(r_count))
        else $error("lookup changed the entry count");

    a_hit_evict_exclusive : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_m_tvalid |-> !(r_hit && r_evicted))
        else $error("result flags both hit and eviction");

endmodule

`default_nettype wire
